/* rtl/core/nbiot_pdsch_gold_scrambler_core_macros.svh */
// Assertion macros shared by the Gold scrambler core.
// Plain text macros; no dependencies.
`ifndef NBIOT_PDSCH_GOLD_SCRAMBLER_CORE_MACROS_SVH
`define NBIOT_PDSCH_GOLD_SCRAMBLER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrambler core check failed");

// Next-cycle implication, disabled during reset.
`define NGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrambler core check failed");

`endif

/* rtl/core/ngs_pkg.sv */
// Package for the Gold scrambler core: widths, defaults, codes and types.
// No dependencies.
`default_nettype none

package ngs_pkg;

    localparam int DATA_W            = 32;
    localparam int LFSR_W            = 31;
    localparam int WORD_BITS_DEF     = 32;
    localparam int WARMUP_STEPS_DEF  = 1600;

    localparam int RNTI_W  = 16;
    localparam int FRAME_W = 10;
    localparam int SLOT_W  = 5;
    localparam int CELL_W  = 9;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // c_init bit positions
    localparam int RNTI_POS  = 14;
    localparam int FRAME_POS = 13;
    localparam int SLOT_POS  = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RNTI  = 2'd0,
        CFG_FRAME = 2'd1,
        CFG_SLOT  = 2'd2,
        CFG_CELL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WARM,
        ST_WORD,
        ST_EMIT
    } state_t;

    // Commands to the generator unit
    typedef struct packed {
        logic load;
        logic step;
    } gen_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/nbiot_pdsch_gold_scrambler_core.sv */
// NB-IoT downlink Gold sequence scrambler, top level.
// Depends on ngs_pkg, ngs_gold_gen and nbiot_pdsch_gold_scrambler_core_macros.svh.
//
// Each input transfer carries 32 code bits (bit j is the j-th bit of the group) and a
// last flag; each output transfer carries the same bits XORed with the next WORD_BITS
// Gold sequence bits. The first word after reset, and the first word after a word
// flagged last, opens a new block: c_init = rnti*2^14 + (frame_number mod 2)*2^13 +
// (slot_number/2)*2^9 + cell_id (sum kept to 31 bits), the first LFSR is set to one,
// and both LFSRs run WARMUP_STEPS steps before any sequence bit is used. One shared
// generator advances a single step per cycle during warm-up and sequence collection;
// it holds while a finished word waits for the output register. The block takes one
// word at a time; s_tready is high only while no word is at work, and the output
// register lets a new word start while a result still waits for m_tready. The user
// must write configuration through cfg_we/cfg_index/cfg_wdata only while idle; the
// block itself does not enforce this. Configuration takes effect at the next block
// start. With WORD_BITS above 32 the extra sequence bits are consumed and dropped;
// below 32 the upper data bits pass unscrambled.
`default_nettype none

`include "nbiot_pdsch_gold_scrambler_core_macros.svh"

module nbiot_pdsch_gold_scrambler_core #(
    parameter int WORD_BITS    = ngs_pkg::WORD_BITS_DEF,
    parameter int WARMUP_STEPS = ngs_pkg::WARMUP_STEPS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [ngs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ngs_pkg::CFG_W-1:0]     cfg_wdata,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ngs_pkg::DATA_W-1:0]    s_tdata,   // [31:0] data_word
    input  wire logic                          s_tlast,   // last_word
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ngs_pkg::DATA_W-1:0]         m_tdata,   // [31:0] scrambled_word
    output logic                               m_tlast    // last
);

    // Counter widths; each counter indexes up to its terminal value only
    localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int WARM_W = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;
    localparam int BIT_LAST  = WORD_BITS - 1;
    localparam int WARM_LAST = (WARMUP_STEPS > 0) ? WARMUP_STEPS - 1 : 0;
    // Sequence bits that land inside the 32-bit result
    localparam int KEEP = (WORD_BITS < ngs_pkg::DATA_W) ? WORD_BITS : ngs_pkg::DATA_W;

    // Configuration registers
    logic [ngs_pkg::RNTI_W-1:0]  rnti_reg;
    logic [ngs_pkg::FRAME_W-1:0] frame_reg;
    logic [ngs_pkg::SLOT_W-1:0]  slot_reg;
    logic [ngs_pkg::CELL_W-1:0]  cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnti_reg  <= '0;
            frame_reg <= '0;
            slot_reg  <= '0;
            cell_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (ngs_pkg::cfg_idx_t'(cfg_index))
                ngs_pkg::CFG_RNTI:  rnti_reg  <= cfg_wdata[ngs_pkg::RNTI_W-1:0];
                ngs_pkg::CFG_FRAME: frame_reg <= cfg_wdata[ngs_pkg::FRAME_W-1:0];
                ngs_pkg::CFG_SLOT:  slot_reg  <= cfg_wdata[ngs_pkg::SLOT_W-1:0];
                ngs_pkg::CFG_CELL:  cell_reg  <= cfg_wdata[ngs_pkg::CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // c_init: terms are added; with these register widths the fields do not overlap, so no carry arises
    logic [ngs_pkg::LFSR_W-1:0] cinit;
    always_comb
    begin
        cinit = {1'b0, rnti_reg, {ngs_pkg::RNTI_POS{1'b0}}}
              + {{(ngs_pkg::LFSR_W-ngs_pkg::FRAME_POS-1){1'b0}}, frame_reg[0],
                 {ngs_pkg::FRAME_POS{1'b0}}}
              + {{(ngs_pkg::LFSR_W-ngs_pkg::SLOT_POS-ngs_pkg::SLOT_W+1){1'b0}},
                 slot_reg[ngs_pkg::SLOT_W-1:1], {ngs_pkg::SLOT_POS{1'b0}}}
              + {{(ngs_pkg::LFSR_W-ngs_pkg::CELL_W){1'b0}}, cell_reg};
    end

    // Sequencer state
    ngs_pkg::state_t              state_reg, state_next;
    logic [BIT_W-1:0]             bit_cnt_reg, bit_cnt_next;
    logic [WARM_W-1:0]            warm_cnt_reg, warm_cnt_next;
    logic                         in_block_reg, in_block_next;
    logic [ngs_pkg::DATA_W-1:0]   data_reg, data_next;
    logic                         last_reg, last_next;
    logic [WORD_BITS-1:0]         seq_reg, seq_next;
    logic                         m_valid_reg, m_valid_next;
    logic [ngs_pkg::DATA_W-1:0]   m_data_reg, m_data_next;
    logic                         m_last_reg, m_last_next;

    ngs_pkg::gen_ctrl_t           gen_ctrl;
    logic                         seq_bit;
    logic                         s_fire;
    logic                         out_free;
    logic [WORD_BITS-1:0]         seq_shift;
    logic [ngs_pkg::DATA_W-1:0]   seq_mask;

    ngs_gold_gen u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (gen_ctrl),
        .cinit   (cinit),
        .seq_bit (seq_bit)
    );

    // Shift each new sequence bit in at the top; after WORD_BITS steps bit j sits at j
    generate
        if (WORD_BITS == 1)
        begin : g_shift_one
            assign seq_shift = seq_bit;
        end
        else
        begin : g_shift_many
            assign seq_shift = {seq_bit, seq_reg[WORD_BITS-1:1]};
        end
    endgenerate

    always_comb
    begin
        seq_mask = '0;
        seq_mask[KEEP-1:0] = seq_reg[KEEP-1:0];
    end

    assign s_tready = (state_reg == ngs_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        warm_cnt_next = warm_cnt_reg;
        in_block_next = in_block_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        seq_next      = seq_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        gen_ctrl      = '0;

        // drop the result once the sink takes it
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ngs_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    data_next     = s_tdata;
                    last_next     = s_tlast;
                    in_block_next = !s_tlast;
                    bit_cnt_next  = '0;
                    warm_cnt_next = '0;
                    if (!in_block_reg)
                    begin
                        // open a block: load the generator, then warm up if WARMUP_STEPS is nonzero
                        gen_ctrl.load = 1'b1;
                        state_next = (WARMUP_STEPS > 0) ? ngs_pkg::ST_WARM
                                                        : ngs_pkg::ST_WORD;
                    end
                    else
                        state_next = ngs_pkg::ST_WORD;
                end
            end
            ngs_pkg::ST_WARM:
            begin
                gen_ctrl.step = 1'b1;
                warm_cnt_next = warm_cnt_reg + 1'b1;
                if (warm_cnt_reg == WARM_W'(WARM_LAST))
                    state_next = ngs_pkg::ST_WORD;
            end
            ngs_pkg::ST_WORD:
            begin
                gen_ctrl.step = 1'b1;
                seq_next      = seq_shift;
                bit_cnt_next  = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_W'(BIT_LAST))
                    state_next = ngs_pkg::ST_EMIT;
            end
            ngs_pkg::ST_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = data_reg ^ seq_mask;
                    m_last_next  = last_reg;
                    state_next   = ngs_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ngs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ngs_pkg::ST_IDLE;
            bit_cnt_reg  <= '0;
            warm_cnt_reg <= '0;
            in_block_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            warm_cnt_reg <= warm_cnt_next;
            in_block_reg <= in_block_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        last_reg   <= last_next;
        seq_reg    <= seq_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // A word that opens a block must go through warm-up first
    `NGS_ASSERT_NEXT(a_open_warms, clk, rst_n,
        s_fire && !in_block_reg && (WARMUP_STEPS > 0), state_reg == ngs_pkg::ST_WARM)
    // A word inside a block goes straight to sequence collection
    `NGS_ASSERT_NEXT(a_cont_word, clk, rst_n,
        s_fire && in_block_reg, state_reg == ngs_pkg::ST_WORD)
    // A pending result is never overwritten
    `NGS_ASSERT_NEXT(a_no_overwrite, clk, rst_n,
        state_reg == ngs_pkg::ST_EMIT && m_valid_reg && !m_tready,
        state_reg == ngs_pkg::ST_EMIT && m_valid_reg)
    // Emitting a result returns to idle with the output register loaded
    `NGS_ASSERT_NEXT(a_emit_loads, clk, rst_n,
        state_reg == ngs_pkg::ST_EMIT && out_free,
        state_reg == ngs_pkg::ST_IDLE && m_valid_reg)

endmodule

`default_nettype wire

/* rtl/core/ngs_gold_gen.sv */
// Length-31 Gold sequence generator: two LFSRs advanced one step per command.
// Depends on ngs_pkg.
`default_nettype none

module ngs_gold_gen (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ngs_pkg::gen_ctrl_t        ctrl,
    input  wire logic [ngs_pkg::LFSR_W-1:0] cinit,
    output logic                           seq_bit
);

    logic [ngs_pkg::LFSR_W-1:0] x1_reg, x1_next;
    logic [ngs_pkg::LFSR_W-1:0] x2_reg, x2_next;

    assign seq_bit = x1_reg[0] ^ x2_reg[0];

    always_comb
    begin
        x1_next = x1_reg;
        x2_next = x2_reg;
        if (ctrl.load)
        begin
            x1_next = {{(ngs_pkg::LFSR_W-1){1'b0}}, 1'b1};
            x2_next = cinit;
        end
        else if (ctrl.step)
        begin
            x1_next = {x1_reg[3] ^ x1_reg[0], x1_reg[ngs_pkg::LFSR_W-1:1]};
            x2_next = {x2_reg[3] ^ x2_reg[2] ^ x2_reg[1] ^ x2_reg[0],
                       x2_reg[ngs_pkg::LFSR_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= {{(ngs_pkg::LFSR_W-1){1'b0}}, 1'b1};
            x2_reg <= '0;
        end
        else
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

endmodule

`default_nettype wire
